>>> rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and helper functions of the alarm clock block.
// ----------------------------------------------------------------------------
`default_nettype none

package acs_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLASH_TICKS      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_SECONDS    = 2'd2;

    localparam logic [15:0] TPS_RESET       = 16'd500;
    localparam logic [15:0] FLASH_RESET     = 16'd100;
    localparam logic [3:0]  ALARM_SEC_RESET = 4'd5;

    // input event codes
    localparam logic [2:0] IN_TICK       = 3'd0;
    localparam logic [2:0] IN_SET_KEY    = 3'd1;
    localparam logic [2:0] IN_ALARM_KEY  = 3'd2;
    localparam logic [2:0] IN_UP_KEY     = 3'd3;
    localparam logic [2:0] IN_DOWN_PRESS = 3'd4;
    localparam logic [2:0] IN_DOWN_REL   = 3'd5;
    localparam logic [2:0] IN_TEMP       = 3'd6;

    // edit modes
    localparam logic [2:0] MODE_RUN     = 3'd0;
    localparam logic [2:0] MODE_SET_H   = 3'd1;
    localparam logic [2:0] MODE_SET_M   = 3'd2;
    localparam logic [2:0] MODE_SET_S   = 3'd3;
    localparam logic [2:0] MODE_ALARM_H = 3'd4;
    localparam logic [2:0] MODE_ALARM_M = 3'd5;
    localparam logic [2:0] MODE_ALARM_S = 3'd6;
    localparam logic [2:0] MODE_TEMP    = 3'd7;

    // edited field
    localparam logic [1:0] FIELD_NONE = 2'd0;
    localparam logic [1:0] FIELD_H    = 2'd1;
    localparam logic [1:0] FIELD_M    = 2'd2;
    localparam logic [1:0] FIELD_S    = 2'd3;

    localparam logic [7:0] SEG_DASH  = 8'hBF;
    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEG_C     = 8'hC6;
    localparam logic [7:0] LED_ON    = 8'hFE;
    localparam logic [7:0] LED_OFF   = 8'hFF;

    localparam logic [6:0] TEMP_MAX  = 7'd99;
    localparam logic [5:0] LIMIT_H   = 6'd24;
    localparam logic [5:0] LIMIT_MS  = 6'd60;

    typedef enum logic [2:0] {
        EV_TICK,
        EV_SET_KEY,
        EV_ALARM_KEY,
        EV_UP,
        EV_DOWN_PRESS,
        EV_DOWN_RELEASE,
        EV_TEMP,
        EV_NONE
    } event_t;

    typedef struct packed {
        event_t     kind;
        logic [6:0] temp;
    } cmd_t;

    typedef struct packed {
        logic [2:0] digit_select;
        logic [7:0] segment_code;
        logic [7:0] led_pattern;
        logic       alarm_active;
        logic [2:0] edit_mode;
    } result_t;

    function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] limit);
        logic [6:0] inc;
        inc = {1'b0, v} + 7'd1;
        return (inc >= {1'b0, limit}) ? 6'd0 : inc[5:0];
    endfunction

    function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] limit);
        return (v == 6'd0 || v >= limit) ? limit - 6'd1 : v - 6'd1;
    endfunction

    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [3:0] t;
        t = 4'd0;
        if (v >= 7'd10) t = 4'd1;
        if (v >= 7'd20) t = 4'd2;
        if (v >= 7'd30) t = 4'd3;
        if (v >= 7'd40) t = 4'd4;
        if (v >= 7'd50) t = 4'd5;
        if (v >= 7'd60) t = 4'd6;
        if (v >= 7'd70) t = 4'd7;
        if (v >= 7'd80) t = 4'd8;
        if (v >= 7'd90) t = 4'd9;
        return t;
    endfunction

    function automatic logic [3:0] units_of(input logic [6:0] v);
        logic [3:0] t;
        logic [6:0] r;
        t = tens_of(v);
        r = v - ({3'd0, t} * 7'd10);
        return r[3:0];
    endfunction

    function automatic logic [7:0] seg_digit(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hC0;
            4'd1:    s = 8'hF9;
            4'd2:    s = 8'hA4;
            4'd3:    s = 8'hB0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hF8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h90;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/acs_in_if.sv
// ----------------------------------------------------------------------------
// acs_in_if
// Event channel: valid/ready handshake with event code and temperature.
// ----------------------------------------------------------------------------
`default_nettype none

interface acs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [6:0] temperature;

    modport source (output valid, output mode, output temperature, input ready);
    modport sink   (input valid, input mode, input temperature, output ready);
endinterface

`default_nettype wire

>>> rtl/acs_out_if.sv
// ----------------------------------------------------------------------------
// acs_out_if
// Result channel: valid/ready handshake with display and LED fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface acs_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] digit_select;
    logic [7:0] segment_code;
    logic [7:0] led_pattern;
    logic       alarm_active;
    logic [2:0] edit_mode;

    modport source (output valid, output digit_select, output segment_code,
                    output led_pattern, output alarm_active, output edit_mode,
                    input ready);
    modport sink   (input valid, input digit_select, input segment_code,
                    input led_pattern, input alarm_active, input edit_mode,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/acs_front.sv
// ----------------------------------------------------------------------------
// acs_front
// Accepts event requests, decodes the event code and clamps temperature.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_front
    import acs_pkg::*;
(
    acs_in_if.sink     events,
    output logic       push,
    output cmd_t       push_cmd,
    input  logic       push_ready
);

    event_t kind;

    always_comb
    begin
        unique case (events.mode)
            IN_TICK:       kind = EV_TICK;
            IN_SET_KEY:    kind = EV_SET_KEY;
            IN_ALARM_KEY:  kind = EV_ALARM_KEY;
            IN_UP_KEY:     kind = EV_UP;
            IN_DOWN_PRESS: kind = EV_DOWN_PRESS;
            IN_DOWN_REL:   kind = EV_DOWN_RELEASE;
            IN_TEMP:       kind = EV_TEMP;
            default:       kind = EV_NONE;
        endcase
    end

    assign events.ready  = push_ready;
    assign push          = events.valid & push_ready;
    assign push_cmd.kind = kind;
    assign push_cmd.temp = (events.temperature > TEMP_MAX) ? TEMP_MAX : events.temperature;

endmodule

`default_nettype wire

>>> rtl/acs_queue.sv
// ----------------------------------------------------------------------------
// acs_queue
// Two-entry command queue between front and back, push and pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_queue
    import acs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (!push && pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> rtl/acs_back.sv
// ----------------------------------------------------------------------------
// acs_back
// Clock state, event execution, display scan and alarm LED; registered result.
// A flash_ticks write re-derives tick_count mod flash_ticks bit-serially.
// ----------------------------------------------------------------------------
`default_nettype none

module acs_back
    import acs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    input  cmd_t                   cmd,
    output logic                   pop,
    acs_out_if.source              results
);

    logic [15:0] tps_reg;
    logic [15:0] flash_reg;
    logic [3:0]  alarm_sec_reg;

    logic [15:0] tick_count_reg,  tick_count_next;
    logic [15:0] flash_rem_reg,   flash_rem_next;
    logic [4:0]  hours_reg,       hours_next;
    logic [5:0]  minutes_reg,     minutes_next;
    logic [5:0]  seconds_reg,     seconds_next;
    logic [4:0]  edit_hours_reg,  edit_hours_next;
    logic [5:0]  edit_minutes_reg, edit_minutes_next;
    logic [5:0]  edit_seconds_reg, edit_seconds_next;
    logic [4:0]  alarm_hours_reg, alarm_hours_next;
    logic [5:0]  alarm_minutes_reg, alarm_minutes_next;
    logic [5:0]  alarm_secs_reg,  alarm_secs_next;
    logic [2:0]  mode_reg,        mode_next;
    logic        alarm_flag_reg,  alarm_flag_next;
    logic [3:0]  elapsed_reg,     elapsed_next;
    logic        led_phase_reg,   led_phase_next;
    logic        blink_reg,       blink_next;
    logic [2:0]  scan_reg,        scan_next;
    logic [6:0]  temp_reg,        temp_next;

    logic        busy_reg;
    logic [3:0]  bit_idx_reg;
    logic        out_valid_reg;
    result_t     result_reg, result_next;

    logic [15:0] flash_eff;
    logic [16:0] div_shift;
    logic [16:0] div_diff;
    logic        exec;

    assign flash_eff = (flash_reg == 16'd0) ? 16'd1 : flash_reg;
    assign div_shift = {flash_rem_reg, tick_count_reg[bit_idx_reg]};
    assign div_diff  = div_shift - {1'b0, flash_eff};
    assign exec      = cmd_valid && !busy_reg && !cfg_we
                       && (!out_valid_reg || results.ready);
    assign pop       = exec;

    // event execution
    always_comb
    begin
        logic [15:0] tc_inc;
        logic [16:0] rem_inc;
        logic [15:0] rem_wrap;
        logic [4:0]  elapsed_inc;
        logic [2:0]  adj_mode;
        logic        adj_en;
        logic        adj_up;
        logic [5:0]  fld;

        tick_count_next    = tick_count_reg;
        flash_rem_next     = flash_rem_reg;
        hours_next         = hours_reg;
        minutes_next       = minutes_reg;
        seconds_next       = seconds_reg;
        edit_hours_next    = edit_hours_reg;
        edit_minutes_next  = edit_minutes_reg;
        edit_seconds_next  = edit_seconds_reg;
        alarm_hours_next   = alarm_hours_reg;
        alarm_minutes_next = alarm_minutes_reg;
        alarm_secs_next    = alarm_secs_reg;
        mode_next          = mode_reg;
        alarm_flag_next    = alarm_flag_reg;
        elapsed_next       = elapsed_reg;
        led_phase_next     = led_phase_reg;
        blink_next         = blink_reg;
        scan_next          = scan_reg;
        temp_next          = temp_reg;
        adj_en             = 1'b0;
        adj_up             = 1'b0;
        fld                = 6'd0;

        tc_inc      = tick_count_reg + 16'd1;
        rem_inc     = {1'b0, flash_rem_reg} + 17'd1;
        rem_wrap    = (tc_inc == 16'd0 || rem_inc == {1'b0, flash_eff}) ? 16'd0
                                                                         : rem_inc[15:0];
        elapsed_inc = {1'b0, elapsed_reg} + {4'd0, alarm_flag_reg};

        case (cmd.kind)
            EV_TICK:
            begin
                tick_count_next = tc_inc;
                flash_rem_next  = rem_wrap;
                scan_next       = scan_reg + 3'd1;
                if (alarm_flag_reg && rem_wrap == 16'd0)
                    led_phase_next = ~led_phase_reg;
                if (tc_inc >= tps_reg)
                begin
                    tick_count_next = 16'd0;
                    flash_rem_next  = 16'd0;
                    if (elapsed_inc > {1'b0, alarm_sec_reg})
                    begin
                        elapsed_next    = 4'd0;
                        alarm_flag_next = 1'b0;
                        led_phase_next  = 1'b0;
                    end
                    else
                        elapsed_next = elapsed_inc[3:0];
                    blink_next   = ~blink_reg;
                    seconds_next = wrap_up(seconds_reg, LIMIT_MS);
                    if (seconds_next == 6'd0)
                    begin
                        minutes_next = wrap_up(minutes_reg, LIMIT_MS);
                        if (minutes_next == 6'd0)
                            hours_next = 5'(wrap_up({1'b0, hours_reg}, LIMIT_H));
                    end
                end
            end
            EV_SET_KEY:
            begin
                edit_hours_next   = hours_reg;
                edit_minutes_next = minutes_reg;
                edit_seconds_next = seconds_reg;
                mode_next = (mode_reg >= MODE_SET_S && mode_reg != MODE_TEMP + 3'd0)
                            ? MODE_RUN : mode_reg + 3'd1;
                if (mode_reg == MODE_TEMP)
                    mode_next = MODE_RUN;
            end
            EV_ALARM_KEY:
            begin
                if (mode_reg < MODE_ALARM_H)
                    mode_next = MODE_ALARM_H;
                else if (mode_reg >= MODE_ALARM_S)
                    mode_next = MODE_RUN;
                else
                    mode_next = mode_reg + 3'd1;
            end
            EV_UP:
            begin
                adj_en = 1'b1;
                adj_up = 1'b1;
            end
            EV_DOWN_PRESS:
            begin
                if (mode_reg == MODE_RUN)
                    mode_next = MODE_TEMP;
            end
            EV_DOWN_RELEASE:
            begin
                if (mode_reg == MODE_TEMP)
                    mode_next = MODE_RUN;
                adj_en = 1'b1;
            end
            EV_TEMP:
                temp_next = cmd.temp;
            default:
            begin
            end
        endcase

        adj_mode = mode_next;
        if (adj_en)
        begin
            case (adj_mode)
                MODE_SET_H:
                begin
                    fld = adj_up ? wrap_up({1'b0, edit_hours_reg}, LIMIT_H)
                                 : wrap_down({1'b0, edit_hours_reg}, LIMIT_H);
                    edit_hours_next = fld[4:0];
                    hours_next      = fld[4:0];
                end
                MODE_SET_M:
                begin
                    fld = adj_up ? wrap_up(edit_minutes_reg, LIMIT_MS)
                                 : wrap_down(edit_minutes_reg, LIMIT_MS);
                    edit_minutes_next = fld;
                    minutes_next      = fld;
                end
                MODE_SET_S:
                begin
                    fld = adj_up ? wrap_up(edit_seconds_reg, LIMIT_MS)
                                 : wrap_down(edit_seconds_reg, LIMIT_MS);
                    edit_seconds_next = fld;
                    seconds_next      = fld;
                end
                MODE_ALARM_H:
                begin
                    fld = adj_up ? wrap_up({1'b0, alarm_hours_reg}, LIMIT_H)
                                 : wrap_down({1'b0, alarm_hours_reg}, LIMIT_H);
                    alarm_hours_next = fld[4:0];
                end
                MODE_ALARM_M:
                    alarm_minutes_next = adj_up ? wrap_up(alarm_minutes_reg, LIMIT_MS)
                                                : wrap_down(alarm_minutes_reg, LIMIT_MS);
                MODE_ALARM_S:
                    alarm_secs_next = adj_up ? wrap_up(alarm_secs_reg, LIMIT_MS)
                                             : wrap_down(alarm_secs_reg, LIMIT_MS);
                default:
                begin
                end
            endcase
        end

        if (hours_next == alarm_hours_next && minutes_next == alarm_minutes_next
            && seconds_next == alarm_secs_next)
            alarm_flag_next = 1'b1;
    end

    // display scan
    always_comb
    begin
        logic [4:0] h;
        logic [5:0] mi;
        logic [5:0] s;
        logic [1:0] edited;
        logic [6:0] val;
        logic       tens;
        logic       blank;
        logic [7:0] seg;

        h      = hours_next;
        mi     = minutes_next;
        s      = seconds_next;
        edited = FIELD_NONE;
        val    = 7'd0;
        tens   = 1'b0;
        blank  = 1'b0;
        seg    = SEG_DASH;

        unique case (mode_next) inside
            MODE_SET_H:   begin h = edit_hours_next;   edited = FIELD_H; end
            MODE_SET_M:   begin mi = edit_minutes_next; edited = FIELD_M; end
            MODE_SET_S:   begin s = edit_seconds_next; edited = FIELD_S; end
            MODE_ALARM_H, MODE_ALARM_M, MODE_ALARM_S:
            begin
                h  = alarm_hours_next;
                mi = alarm_minutes_next;
                s  = alarm_secs_next;
                edited = (mode_next == MODE_ALARM_H) ? FIELD_H :
                         (mode_next == MODE_ALARM_M) ? FIELD_M : FIELD_S;
            end
            default:
            begin
            end
        endcase

        case (scan_reg)
            3'd0:    begin val = {2'd0, h}; tens = 1'b1; blank = (edited == FIELD_H); end
            3'd1:    begin val = {2'd0, h}; tens = 1'b0; blank = (edited == FIELD_H); end
            3'd3:    begin val = {1'b0, mi}; tens = 1'b1; blank = (edited == FIELD_M); end
            3'd4:    begin val = {1'b0, mi}; tens = 1'b0; blank = (edited == FIELD_M); end
            3'd6:    begin val = {1'b0, s}; tens = 1'b1; blank = (edited == FIELD_S); end
            3'd7:    begin val = {1'b0, s}; tens = 1'b0; blank = (edited == FIELD_S); end
            default: val = 7'd0;
        endcase

        if (scan_reg != 3'd2 && scan_reg != 3'd5)
        begin
            seg = seg_digit(tens ? tens_of(val) : units_of(val));
            if (blank && blink_next)
                seg = SEG_BLANK;
        end

        if (mode_next == MODE_TEMP)
        begin
            case (scan_reg)
                3'd5:    seg = seg_digit(tens_of(temp_next));
                3'd6:    seg = seg_digit(units_of(temp_next));
                3'd7:    seg = SEG_C;
                default: seg = SEG_BLANK;
            endcase
        end

        result_next.digit_select = scan_reg;
        result_next.segment_code = seg;
        result_next.led_pattern  = (alarm_flag_next && led_phase_next) ? LED_ON : LED_OFF;
        result_next.alarm_active = alarm_flag_next;
        result_next.edit_mode    = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg           <= TPS_RESET;
            flash_reg         <= FLASH_RESET;
            alarm_sec_reg     <= ALARM_SEC_RESET;
            tick_count_reg    <= 16'd0;
            flash_rem_reg     <= 16'd0;
            hours_reg         <= 5'd23;
            minutes_reg       <= 6'd59;
            seconds_reg       <= 6'd50;
            edit_hours_reg    <= 5'd0;
            edit_minutes_reg  <= 6'd0;
            edit_seconds_reg  <= 6'd0;
            alarm_hours_reg   <= 5'd0;
            alarm_minutes_reg <= 6'd0;
            alarm_secs_reg    <= 6'd0;
            mode_reg          <= MODE_RUN;
            alarm_flag_reg    <= 1'b0;
            elapsed_reg       <= 4'd0;
            led_phase_reg     <= 1'b0;
            blink_reg         <= 1'b0;
            scan_reg          <= 3'd0;
            temp_reg          <= 7'd0;
            busy_reg          <= 1'b0;
            bit_idx_reg       <= 4'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_SECOND: tps_reg <= cfg_data;
                    CFG_FLASH_TICKS:
                    begin
                        flash_reg     <= cfg_data;
                        flash_rem_reg <= 16'd0;
                        busy_reg      <= 1'b1;
                        bit_idx_reg   <= 4'd15;
                    end
                    CFG_ALARM_SECONDS:    alarm_sec_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
            else if (busy_reg)
            begin
                flash_rem_reg <= div_diff[16] ? div_shift[15:0] : div_diff[15:0];
                bit_idx_reg   <= bit_idx_reg - 4'd1;
                if (bit_idx_reg == 4'd0)
                    busy_reg <= 1'b0;
            end
            else if (exec)
            begin
                tick_count_reg    <= tick_count_next;
                flash_rem_reg     <= flash_rem_next;
                hours_reg         <= hours_next;
                minutes_reg       <= minutes_next;
                seconds_reg       <= seconds_next;
                edit_hours_reg    <= edit_hours_next;
                edit_minutes_reg  <= edit_minutes_next;
                edit_seconds_reg  <= edit_seconds_next;
                alarm_hours_reg   <= alarm_hours_next;
                alarm_minutes_reg <= alarm_minutes_next;
                alarm_secs_reg    <= alarm_secs_next;
                mode_reg          <= mode_next;
                alarm_flag_reg    <= alarm_flag_next;
                elapsed_reg       <= elapsed_next;
                led_phase_reg     <= led_phase_next;
                blink_reg         <= blink_next;
                scan_reg          <= scan_next;
                temp_reg          <= temp_next;
            end

            if (exec)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            result_reg <= result_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.digit_select = result_reg.digit_select;
    assign results.segment_code = result_reg.segment_code;
    assign results.led_pattern  = result_reg.led_pattern;
    assign results.alarm_active = result_reg.alarm_active;
    assign results.edit_mode    = result_reg.edit_mode;

endmodule

`default_nettype wire

>>> rtl/alarm_clock_with_set_modes.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_set_modes
// Clock with alarm and edit modes driving a scanned seven-segment display.
// An event passes through the queue, then the result register.
// Throughput: one event per cycle, stalled by cfg_we, busy or back-pressure.
// A flash_ticks write holds the back end busy for the serial remainder.
// Reset: time 23:59:50, all else zero, registers to defaults, queue empty.
// ----------------------------------------------------------------------------
`default_nettype none

module alarm_clock_with_set_modes
    import acs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    acs_in_if.sink                 events,
    acs_out_if.source              results
);

    logic push;
    cmd_t push_cmd;
    logic push_ready;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    acs_front u_front (
        .events     (events),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    acs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    acs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .pop       (pop),
        .results   (results)
    );

endmodule

`default_nettype wire
